// ===== hw/rtl/bps_pkg.sv =====
package bps_pkg;

  localparam int SPACE_RUN_DEPTH = 32;
  localparam int CNT_W = $clog2(SPACE_RUN_DEPTH + 1);
  localparam int IDX_W = (SPACE_RUN_DEPTH > 1) ? $clog2(SPACE_RUN_DEPTH) : 1;

  localparam logic [7:0] BYTE_PFX_HI = 8'hC4;
  localparam logic [7:0] BYTE_PFX_LO = 8'hA0;
  localparam logic [7:0] BYTE_HIGH   = 8'h80;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_WORD  = 2'd1,
    CLS_SPACE = 2'd2,
    CLS_PUNCT = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    EM_PFX_HI = 2'd0,
    EM_PFX_LO = 2'd1,
    EM_BYTE   = 2'd2,
    EM_RUN    = 2'd3
  } emit_t;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  rd;
    logic  emit;
    emit_t kind;
    logic  finish;
  } bps_cmd_t;

  // datapath to controller
  typedef struct packed {
    cls_t in_cls;
    logic in_last;
    cls_t cur_cls;
    cls_t cls;
    logic run_done;
    logic out_free;
  } bps_stat_t;

  function automatic cls_t class_of(input logic [7:0] b);
    cls_t c;
    c = CLS_PUNCT;
    if (b inside {8'h20, 8'h09, 8'h0A, 8'h0D}) begin
      c = CLS_SPACE;
    end else if (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]} ||
                 b >= BYTE_HIGH) begin
      c = CLS_WORD;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/bps_ctrl.sv =====
module bps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bps_pkg::bps_stat_t stat,
  output bps_pkg::bps_cmd_t  cmd
);
  import bps_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PHI  = 6'b000010,
    S_PLO  = 6'b000100,
    S_RD   = 6'b001000,
    S_FL   = 6'b010000,
    S_BYTE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.kind   = EM_BYTE;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (stat.cur_cls == CLS_SPACE && stat.in_cls == CLS_WORD) begin
            state_nxt = S_PHI;
          end else if (stat.in_cls == CLS_SPACE) begin
            state_nxt = stat.in_last ? S_RD : S_IDLE;
          end else if (stat.cur_cls == CLS_SPACE) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_BYTE;
          end
        end
      end
      S_PHI: begin
        cmd.kind = EM_PFX_HI;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_PLO;
        end
      end
      S_PLO: begin
        cmd.kind = EM_PFX_LO;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_BYTE;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FL;
      end
      S_FL: begin
        cmd.kind = EM_RUN;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.run_done) begin
            if (stat.cls == CLS_SPACE) begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt = S_BYTE;
            end
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_BYTE: begin
        cmd.kind = EM_BYTE;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/bps_dpath.sv =====
module bps_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_byte,
  input  logic               in_text_end,
  input  bps_pkg::bps_cmd_t  cmd,
  output bps_pkg::bps_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_token_start,
  output logic               out_run_last,
  output logic               out_stream_end,
  output logic               out_space_overflow
);
  import bps_pkg::*;

  logic [7:0]       space_mem [SPACE_RUN_DEPTH];
  logic [7:0]       rdata_r;
  logic [7:0]       byte_r;
  logic             last_r;
  cls_t             cls_r;
  cls_t             cur_r, cur_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic             drop_r, drop_nxt, drop_eff;
  logic [IDX_W-1:0] idx_r;
  cls_t             in_cls;
  logic             wr_en;
  logic             after_space_word;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_start_r, out_last_r, out_end_r, out_ovf_r;
  logic [7:0]       em_byte;
  logic             em_start, em_ovf;

  assign in_cls   = class_of(in_byte);
  assign cnt_eff  = (cur_r == CLS_SPACE) ? cnt_r : '0;
  assign drop_eff = (cur_r == CLS_SPACE) ? drop_r : 1'b0;
  assign wr_en    = cmd.load && (in_cls == CLS_SPACE) &&
                    (cnt_eff < CNT_W'(SPACE_RUN_DEPTH));
  assign after_space_word = (cur_r == CLS_SPACE) && (cls_r == CLS_WORD);

  assign stat.in_cls   = in_cls;
  assign stat.in_last  = in_text_end;
  assign stat.cur_cls  = cur_r;
  assign stat.cls      = cls_r;
  assign stat.run_done = (CNT_W'({1'b0, idx_r}) + CNT_W'(1)) == cnt_r;
  assign stat.out_free = !out_valid_r || out_ready;

  // class, run length and overflow bookkeeping
  always_comb begin
    cur_nxt  = cur_r;
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    if (cmd.load && in_cls == CLS_SPACE) begin
      cur_nxt = CLS_SPACE;
      if (wr_en) begin
        cnt_nxt  = cnt_eff + CNT_W'(1);
        drop_nxt = drop_eff;
      end else begin
        cnt_nxt  = cnt_eff;
        drop_nxt = 1'b1;
      end
    end else if (cmd.finish) begin
      cur_nxt = last_r ? CLS_NONE : cls_r;
      if (last_r || cls_r != CLS_SPACE) begin
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= CLS_NONE;
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      cur_r  <= cur_nxt;
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      space_mem[cnt_eff[IDX_W-1:0]] <= in_byte;
    end
    if (cmd.rd) begin
      rdata_r <= space_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_byte;
      last_r <= in_text_end;
      cls_r  <= in_cls;
      idx_r  <= '0;
    end else if (cmd.emit && cmd.kind == EM_RUN) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    em_byte  = byte_r;
    em_start = 1'b0;
    em_ovf   = 1'b0;
    case (cmd.kind)
      EM_PFX_HI: begin
        em_byte  = BYTE_PFX_HI;
        em_start = 1'b1;
        em_ovf   = drop_r;
      end
      EM_PFX_LO: begin
        em_byte = BYTE_PFX_LO;
        em_ovf  = drop_r;
      end
      EM_RUN: begin
        em_byte  = rdata_r;
        em_start = (idx_r == '0);
        em_ovf   = drop_r;
      end
      EM_BYTE: begin
        em_byte  = byte_r;
        em_start = (cur_r != cls_r) && !after_space_word;
        em_ovf   = after_space_word && drop_r;
      end
      default: begin
        em_byte = byte_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r  <= em_byte;
      out_start_r <= em_start;
      out_ovf_r   <= em_ovf;
      out_last_r  <= cmd.finish;
      out_end_r   <= cmd.finish && last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_token_start    = out_start_r;
  assign out_run_last       = out_last_r;
  assign out_stream_end     = out_end_r;
  assign out_space_overflow = out_ovf_r;

endmodule

// ===== hw/rtl/byte_pretoken_splitter_unit.sv =====
// a word or punctuation byte is loaded on acceptance, then sent to the output register from the byte state
// a word byte after a whitespace run gives C4, A0 and the byte, in that order, as the output frees up
// flushing a held run takes a registered buffer read, then output, for each byte
// a new request is taken only once the controller is back in idle after finishing the current one
// reset: synchronous active-low rst_n clears class, run count, overflow flag and output valid
module byte_pretoken_splitter_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_text_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_token_start,
  output logic       out_run_last,
  output logic       out_stream_end,
  output logic       out_space_overflow
);
  import bps_pkg::*;

  // command and status between sequencer and datapath
  bps_cmd_t  cmd;
  bps_stat_t stat;

  // sequencer: takes one request at a time, then steps through prefix,
  // run flush and trailing byte as the output register frees up
  bps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: byte classifier, whitespace run buffer, class and overflow
  // tracking, and the output register that parts the two channels
  bps_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_byte            (in_byte),
    .in_text_end        (in_text_end),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_token_start    (out_token_start),
    .out_run_last       (out_run_last),
    .out_stream_end     (out_stream_end),
    .out_space_overflow (out_space_overflow)
  );

endmodule

// ===== hw/rtl/bps_checker.sv =====
module bps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       in_text_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_token_start,
  input logic       out_run_last,
  input logic       out_stream_end,
  input logic       out_space_overflow
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_text_end))
    else $error("request withdrawn or changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_token_start) && $stable(out_run_last) &&
      $stable(out_stream_end) && $stable(out_space_overflow))
    else $error("result dropped or changed while stalled");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_stream_end || out_run_last))
    else $error("stream end on a result that is not the last of its request");

  a_no_take_mid_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> !in_ready)
    else $error("new request taken before the current one finished");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind byte_pretoken_splitter_unit bps_checker u_bps_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bps_pkg::*;

  // no request moving on either side for this many cycles ends the run
  localparam int WATCHDOG_LIMIT = 2000;
  // the long receiver hold-off, well beyond what the block can buffer
  localparam int SINK_HOLD      = 400;
  // requests in the random part
  localparam int RANDOM_ITEMS   = 45;
  // cycles allowed after the last result for anything stray to show up
  localparam int TAIL_CYCLES    = 20;

  // one byte of the pretokenised stream as the block should deliver it
  typedef struct packed {
    logic [7:0] value;
    logic       start;
    logic       run_last;
    logic       s_end;
    logic       ovf;
  } pretoken_byte_t;

  logic       clk                = 1'b0;
  logic       rst_n              = 1'b0;
  logic       in_valid           = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte            = 8'h00;
  logic       in_text_end        = 1'b0;
  logic       out_valid;
  logic       out_ready          = 1'b0;
  logic [7:0] out_byte;
  logic       out_token_start;
  logic       out_run_last;
  logic       out_stream_end;
  logic       out_space_overflow;

  // expected output bytes, oldest first
  pretoken_byte_t expected_bytes[$];

  // shadow of the splitter state
  cls_t       cur_cls;
  logic [7:0] ws_held [SPACE_RUN_DEPTH];
  int         ws_count;
  logic       ws_dropped;

  int mismatches    = 0;
  int requests_sent = 0;
  int idle_cycles   = 0;

  // idling controls shared with the driving processes
  int src_gap_max  = 19;
  int sink_gap_max = 19;
  int sink_hold    = 0;

  byte_pretoken_splitter_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .in_text_end        (in_text_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_token_start    (out_token_start),
    .out_run_last       (out_run_last),
    .out_stream_end     (out_stream_end),
    .out_space_overflow (out_space_overflow)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // byte classification and pretoken prediction
  // ---------------------------------------------------------------------

  function automatic cls_t byte_class(input logic [7:0] b);
    cls_t c;
    case (b)
      8'h09, 8'h0A, 8'h0D, 8'h20: c = CLS_SPACE;
      default: begin
        // top-bit bytes count as word bytes, as do ascii digits and letters
        if (b[7] || (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h61 && b <= 8'h7A)) begin
          c = CLS_WORD;
        end else begin
          c = CLS_PUNCT;
        end
      end
    endcase
    return c;
  endfunction

  function automatic void push_expected(input logic [7:0] value, input logic start,
                                        input logic ovf);
    pretoken_byte_t t;
    t = '{value: value, start: start, run_last: 1'b0, s_end: 1'b0, ovf: ovf};
    expected_bytes = {expected_bytes, t};
  endfunction

  // held whitespace goes out as its own token, first byte opening it
  function automatic void release_held_run();
    for (int i = 0; i < ws_count; i++) begin
      push_expected(ws_held[i], i == 0, ws_dropped);
    end
    ws_count   = 0;
    ws_dropped = 1'b0;
  endfunction

  function automatic void predict_pretokens(input logic [7:0] b, input logic last);
    cls_t           c;
    int             queued;
    pretoken_byte_t tail;
    c      = byte_class(b);
    queued = expected_bytes.size();
    if (cur_cls == CLS_SPACE && c == CLS_WORD) begin
      // the whole run collapses into the two-byte space marker
      push_expected(BYTE_PFX_HI, 1'b1, ws_dropped);
      push_expected(BYTE_PFX_LO, 1'b0, ws_dropped);
      push_expected(b, 1'b0, ws_dropped);
      ws_count   = 0;
      ws_dropped = 1'b0;
    end else if (c == CLS_SPACE) begin
      if (cur_cls != CLS_SPACE) begin
        ws_count   = 0;
        ws_dropped = 1'b0;
      end
      if (ws_count < SPACE_RUN_DEPTH) begin
        ws_held[ws_count] = b;
        ws_count++;
      end else begin
        ws_dropped = 1'b1;
      end
      if (last) begin
        release_held_run();
      end
    end else begin
      if (cur_cls == CLS_SPACE) begin
        release_held_run();
      end
      push_expected(b, cur_cls != c, 1'b0);
    end
    // the last byte caused by this request carries the run and stream flags
    if (expected_bytes.size() > queued) begin
      tail           = expected_bytes.pop_back();
      tail.run_last  = 1'b1;
      tail.s_end     = last;
      expected_bytes = {expected_bytes, tail};
    end
    if (last) begin
      cur_cls    = CLS_NONE;
      ws_count   = 0;
      ws_dropped = 1'b0;
    end else begin
      cur_cls = c;
    end
  endfunction

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  function automatic logic [7:0] pick_byte(input cls_t c);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (byte_class(b) != c);
    return b;
  endfunction

  // offer one request, hold it until taken, then idle for a random gap;
  // valid stays high across a zero gap so back-to-back requests never glitch
  task automatic send_request(input logic [7:0] b, input logic last);
    int gap;
    in_valid    <= 1'b1;
    in_byte     <= b;
    in_text_end <= last;
    do @(posedge clk); while (!in_ready);
    predict_pretokens(b, last);
    requests_sent++;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender stops until every expected byte has come back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------

  // receiver: random stall before each byte, or a long hold-off on demand
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = $urandom_range(0, sink_gap_max);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      // leave early if a hold-off is requested while nothing is on offer
      do @(posedge clk); while (!out_valid && sink_hold == 0);
    end
  end

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    pretoken_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %02h", $time, out_byte);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        check_field("out_byte", want.value, out_byte);
        check_field("out_token_start", want.start, out_token_start);
        check_field("out_run_last", want.run_last, out_run_last);
        check_field("out_stream_end", want.s_end, out_stream_end);
        check_field("out_space_overflow", want.ovf, out_space_overflow);
      end
    end
  end

  // hang detection: counts cycles in which no request moves on either side
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // class changes and repeats without whitespace, field extremes included
  task automatic test_plain_bytes();
    send_request(8'h00, 1'b0);  // punctuation opens the first token
    send_request(8'h21, 1'b0);  // punctuation continues
    send_request(8'h41, 1'b0);  // word opens
    send_request(8'h7A, 1'b0);
    send_request(8'h30, 1'b0);
    send_request(8'h39, 1'b0);
    send_request(8'h80, 1'b0);  // lowest high byte is a word byte
    send_request(8'hFF, 1'b0);
    send_request(8'h7F, 1'b0);  // delete is punctuation
    send_request(8'h2E, 1'b1);  // end of text on punctuation
  endtask

  // whitespace before word, before punctuation and at end of text
  task automatic test_space_runs();
    send_request(8'h20, 1'b0);
    send_request(8'h78, 1'b0);  // space marker then the word byte
    send_request(8'h09, 1'b0);
    send_request(8'h0A, 1'b0);
    send_request(8'h21, 1'b0);  // run flushed as its own token, then '!'
    send_request(8'h61, 1'b0);
    send_request(8'h20, 1'b0);
    send_request(8'h0D, 1'b1);  // run flushed at end of text
    send_request(8'h20, 1'b1);  // text of a single whitespace byte
    send_request(8'h62, 1'b0);
    send_request(8'h63, 1'b1);  // end of text on a word byte
  endtask

  // runs beyond the buffer depth, first with the receiver held off so the
  // flush backs up into the block and stalls its input
  task automatic test_overflow_under_backpressure();
    src_gap_max = 0;
    sink_hold   = SINK_HOLD;
    send_request(8'h77, 1'b0);
    repeat (SPACE_RUN_DEPTH + 6) send_request(pick_byte(CLS_SPACE), 1'b0);
    send_request(8'h3B, 1'b0);
    for (int k = 0; k < 8; k++) begin
      send_request(8'(8'h61 + k), 1'b0);
    end
    pause_until_drained();
    src_gap_max = 19;
    // exactly full buffer, nothing dropped
    repeat (SPACE_RUN_DEPTH) send_request(pick_byte(CLS_SPACE), 1'b0);
    send_request(8'h71, 1'b0);
    // one byte too many, marker carries the overflow flag
    repeat (SPACE_RUN_DEPTH + 1) send_request(pick_byte(CLS_SPACE), 1'b0);
    send_request(8'h51, 1'b0);
    // overflowed run flushed by end of text
    repeat (SPACE_RUN_DEPTH + 1) send_request(pick_byte(CLS_SPACE), 1'b0);
    send_request(8'h0A, 1'b1);
  endtask

  // mostly well-formed texts with random content, some noise and open texts
  task automatic test_random_texts();
    int   first;
    int   n;
    int   len;
    int   pick;
    cls_t c;
    logic closes;
    first = requests_sent;
    while (requests_sent - first < RANDOM_ITEMS) begin
      // now and then a text runs flat out on both sides
      if ($urandom_range(0, 4) == 0) begin
        src_gap_max  = 0;
        sink_gap_max = 0;
      end else begin
        src_gap_max  = 19;
        sink_gap_max = 19;
      end
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        repeat (n) send_request(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end else begin
        n      = $urandom_range(1, 8);
        closes = $urandom_range(0, 7) != 0;
        for (int k = 0; k < n; k++) begin
          pick = $urandom_range(0, 19);
          if (pick < 9) begin
            c = CLS_WORD;
          end else if (pick < 15) begin
            c = CLS_SPACE;
          end else begin
            c = CLS_PUNCT;
          end
          // the odd long run crosses the buffer depth
          if (c == CLS_SPACE && $urandom_range(0, 9) == 0) begin
            len = $urandom_range(SPACE_RUN_DEPTH - 4, SPACE_RUN_DEPTH + 4);
          end else begin
            len = $urandom_range(1, 4);
          end
          for (int i = 0; i < len; i++) begin
            send_request(pick_byte(c), closes && k == n - 1 && i == len - 1);
          end
        end
      end
    end
    src_gap_max  = 19;
    sink_gap_max = 19;
    send_request(8'h2E, 1'b1);  // close whatever text is still open
  endtask

  initial begin : stimulus
    cur_cls    = CLS_NONE;
    ws_count   = 0;
    ws_dropped = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_bytes();
    test_space_runs();
    pause_until_drained();
    test_overflow_under_backpressure();
    test_random_texts();
    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== byte_pretoken_splitter_unit.f =====
hw/rtl/bps_pkg.sv
hw/rtl/bps_ctrl.sv
hw/rtl/bps_dpath.sv
hw/rtl/byte_pretoken_splitter_unit.sv
hw/rtl/bps_checker.sv
test/testbench.sv
